FILE: sv/istff_pkg.sv
// Package for the image slot table first-fit unit.
// Holds table sizes, field widths, operation and error codes, FSM states and the
// sector round-up helper. It depends on nothing.
package istff_pkg;

  localparam int MAX_ENTRIES  = 8;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W       = 22;
  localparam int SIZE_W       = 22;
  localparam int VER_W        = 32;
  localparam int HDR_W        = 12;
  localparam int END_W        = 23;
  localparam int SECTOR_BYTES = 4096;
  localparam int POS_W        = 25;
  localparam int SUM_W        = 27;

  localparam logic [1:0] CFG_AREA_START   = 2'd0;
  localparam logic [1:0] CFG_AREA_END     = 2'd1;
  localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic [END_W-1:0] AREA_END_RESET = 23'h3F0000;
  localparam logic [HDR_W-1:0] HEADER_RESET   = 12'd64;

  typedef enum logic [2:0] {
    FN_REGISTER     = 3'd0,
    FN_ACTIVATE     = 3'd1,
    FN_DELETE       = 3'd2,
    FN_FIND_FREE    = 3'd3,
    FN_FREE_SPACE   = 3'd4,
    FN_GET_ACTIVE   = 3'd5,
    FN_FIND_VERSION = 3'd6,
    FN_UNDEFINED    = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NOT_FOUND  = 3'd1,
    ERR_TABLE_FULL = 3'd2,
    ERR_NO_SPACE   = 3'd3,
    ERR_ZERO_SIZE  = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_SHIFT,
    ST_FF_CHECK,
    ST_FF_SCAN,
    ST_FREE,
    ST_TOTAL
  } state_t;

  // Round up to the next whole sector.
  function automatic logic [POS_W-1:0] round_up(input logic [POS_W-1:0] x);
    logic [POS_W-1:0] mask;
    mask = POS_W'(SECTOR_BYTES - 1);
    return (x + mask) & ~mask;
  endfunction

endpackage

FILE: sv/image_slot_table_first_fit_unit.sv
// Top level of the image slot table first-fit unit.
// Uses istff_pkg for widths, codes, states and the sector round-up.
//
// One item carries one operation on a table of up to eight image regions and gives
// exactly one result item. A small sequencer walks the table one entry per cycle
// through shared span arithmetic. Its passes are the lookup pass, an optional
// compaction pass for delete, and a final free-space pass run for every item.
// Find-free restarts its pass after each jump past an overlapping region. The
// input is not ready while an item is in work or while its result waits in the
// output register.
module image_slot_table_first_fit_unit
  import istff_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_address[21:0], image_size[43:22], image_version[75:44], zero fill
  input  logic [79:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok[0], error_code[3:1], out_address[25:4], out_size[47:26],
  // out_version[79:48], free_bytes[102:80], entry_total[106:103], zero fill
  output logic [111:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [22:0]  cfg_data
);

  // Table storage; only entries below the count are ever read.
  logic [ADDR_W-1:0] slot_addr_r [MAX_ENTRIES];
  logic [SIZE_W-1:0] slot_size_r [MAX_ENTRIES];
  logic [VER_W-1:0]  slot_ver_r  [MAX_ENTRIES];
  logic              slot_act_r  [MAX_ENTRIES];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  hit_r, hit_nxt;
  logic              found_r, found_nxt;
  state_t            state_r, state_nxt;

  logic [ADDR_W-1:0] area_start_r;
  logic [END_W-1:0]  area_end_r;
  logic [HDR_W-1:0]  header_r;

  func_t             func_r, func_nxt;
  logic [ADDR_W-1:0] tgt_r, tgt_nxt;
  logic [SIZE_W-1:0] isize_r, isize_nxt;
  logic [VER_W-1:0]  iver_r, iver_nxt;

  logic [POS_W-1:0]  cur_r, cur_nxt;
  logic [POS_W-1:0]  req_r, req_nxt;
  logic [POS_W-1:0]  creq_r, creq_nxt;
  logic [SUM_W-1:0]  used_r, used_nxt;

  logic              res_ok_r, res_ok_nxt;
  err_t              res_err_r, res_err_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;
  logic [VER_W-1:0]  res_ver_r, res_ver_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [111:0]      out_data_r, out_data_nxt;

  // Single read port into the table.
  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [SIZE_W-1:0] rd_size;
  logic [VER_W-1:0]  rd_ver;
  logic              rd_act;

  // Write ports: a full entry write and an active-mark-only write.
  logic              wr_en, act_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [SIZE_W-1:0] wr_size;
  logic [VER_W-1:0]  wr_ver;
  logic              wr_act, act_val;

  logic              in_acc, goto_free, match;
  logic [POS_W-1:0]  span_e, span_len;
  logic [END_W-1:0]  total;
  logic [END_W-1:0]  free_val;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign rd_idx  = (state_r == ST_SHIFT) ? IDX_W'(idx_r + 1'b1) : idx_r[IDX_W-1:0];
  assign rd_addr = slot_addr_r[rd_idx];
  assign rd_size = slot_size_r[rd_idx];
  assign rd_ver  = slot_ver_r[rd_idx];
  assign rd_act  = slot_act_r[rd_idx];

  // Shared span arithmetic for the current entry.
  assign span_e   = round_up(POS_W'(rd_addr) + POS_W'(rd_size) + POS_W'(header_r));
  assign span_len = round_up(POS_W'(rd_size) + POS_W'(header_r));

  assign total    = (area_end_r > {1'b0, area_start_r}) ?
                    area_end_r - {1'b0, area_start_r} : '0;
  assign free_val = (used_r >= SUM_W'(total)) ? '0 : total - used_r[END_W-1:0];

  always_comb begin
    unique case (func_r)
      FN_GET_ACTIVE:   match = rd_act;
      FN_FIND_VERSION: match = (rd_ver == iver_r);
      default:         match = (rd_addr == tgt_r);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    func_nxt      = func_r;
    tgt_nxt       = tgt_r;
    isize_nxt     = isize_r;
    iver_nxt      = iver_r;
    cur_nxt       = cur_r;
    req_nxt       = req_r;
    creq_nxt      = creq_r;
    used_nxt      = used_r;
    res_ok_nxt    = res_ok_r;
    res_err_nxt   = res_err_r;
    res_addr_nxt  = res_addr_r;
    res_size_nxt  = res_size_r;
    res_ver_nxt   = res_ver_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    goto_free     = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = hit_r;
    wr_addr       = tgt_r;
    wr_size       = isize_r;
    wr_ver        = iver_r;
    wr_act        = 1'b0;
    act_en        = 1'b0;
    act_val       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt     = func_t'(in_tuser);
          tgt_nxt      = in_tdata[21:0];
          isize_nxt    = in_tdata[43:22];
          iver_nxt     = in_tdata[75:44];
          found_nxt    = 1'b0;
          res_ok_nxt   = 1'b0;
          res_err_nxt  = ERR_NONE;
          res_addr_nxt = '0;
          res_size_nxt = '0;
          res_ver_nxt  = '0;
          idx_nxt      = '0;
          unique case (func_t'(in_tuser))
            FN_FIND_FREE: begin
              if (in_tdata[43:22] == '0) begin
                res_err_nxt = ERR_ZERO_SIZE;
                goto_free   = 1'b1;
              end else begin
                req_nxt   = POS_W'(in_tdata[43:22]) + POS_W'(header_r);
                cur_nxt   = round_up(POS_W'(area_start_r));
                state_nxt = ST_FF_CHECK;
              end
            end
            FN_FREE_SPACE: begin
              res_ok_nxt = 1'b1;
              goto_free  = 1'b1;
            end
            FN_UNDEFINED: goto_free = 1'b1;
            default:      state_nxt = ST_SCAN;
          endcase
        end
      end

      ST_SCAN: begin
        if (idx_r == count_r) begin
          if (func_r == FN_REGISTER) begin
            if (count_r == CNT_W'(MAX_ENTRIES)) begin
              res_err_nxt = ERR_TABLE_FULL;
              goto_free   = 1'b1;
            end else begin
              hit_nxt   = count_r[IDX_W-1:0];
              state_nxt = ST_APPLY;
            end
          end else begin
            res_ok_nxt  = found_r;
            res_err_nxt = found_r ? ERR_NONE : ERR_NOT_FOUND;
            goto_free   = 1'b1;
          end
        end else begin
          unique case (func_r)
            FN_ACTIVATE: begin
              act_en  = 1'b1;
              act_val = match;
              if (match && !found_r) begin
                found_nxt    = 1'b1;
                res_addr_nxt = rd_addr;
                res_size_nxt = rd_size;
                res_ver_nxt  = rd_ver;
              end
              idx_nxt = idx_r + 1'b1;
            end
            FN_REGISTER: begin
              if (match) begin
                found_nxt = 1'b1;
                hit_nxt   = idx_r[IDX_W-1:0];
                state_nxt = ST_APPLY;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: begin
              if (match) begin
                res_ok_nxt   = 1'b1;
                res_addr_nxt = rd_addr;
                res_size_nxt = rd_size;
                res_ver_nxt  = rd_ver;
                if (func_r == FN_DELETE) begin
                  state_nxt = ST_SHIFT;
                end else begin
                  goto_free = 1'b1;
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          endcase
        end
      end

      ST_APPLY: begin
        wr_en        = 1'b1;
        res_ok_nxt   = 1'b1;
        res_addr_nxt = tgt_r;
        res_size_nxt = isize_r;
        res_ver_nxt  = iver_r;
        if (!found_r) begin
          count_nxt = count_r + 1'b1;
        end
        goto_free = 1'b1;
      end

      ST_SHIFT: begin
        // Move the later entries down by one over the removed one.
        if ((idx_r + 1'b1) < count_r) begin
          wr_en   = 1'b1;
          wr_idx  = idx_r[IDX_W-1:0];
          wr_addr = rd_addr;
          wr_size = rd_size;
          wr_ver  = rd_ver;
          wr_act  = rd_act;
          idx_nxt = idx_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          goto_free = 1'b1;
        end
      end

      ST_FF_CHECK: begin
        if (cur_r + req_r > POS_W'(area_end_r)) begin
          res_err_nxt = ERR_NO_SPACE;
          goto_free   = 1'b1;
        end else begin
          creq_nxt  = cur_r + req_r;
          idx_nxt   = '0;
          state_nxt = ST_FF_SCAN;
        end
      end

      ST_FF_SCAN: begin
        if (idx_r == count_r) begin
          res_ok_nxt   = 1'b1;
          res_addr_nxt = cur_r[ADDR_W-1:0];
          goto_free    = 1'b1;
        end else if (!(creq_r <= POS_W'(rd_addr) || cur_r >= span_e)) begin
          cur_nxt   = span_e;
          state_nxt = ST_FF_CHECK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_FREE: begin
        if (idx_r == count_r) begin
          state_nxt = ST_TOTAL;
        end else begin
          used_nxt = used_r + SUM_W'(span_len);
          idx_nxt  = idx_r + 1'b1;
        end
      end

      ST_TOTAL: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {5'd0, count_r, free_val, res_ver_r, res_size_r,
                         res_addr_r, res_err_r, res_ok_r};
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (goto_free) begin
      idx_nxt   = '0;
      used_nxt  = '0;
      state_nxt = ST_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      area_start_r <= '0;
      area_end_r   <= AREA_END_RESET;
      header_r     <= HEADER_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AREA_START:   area_start_r <= cfg_data[ADDR_W-1:0];
          CFG_AREA_END:     area_end_r   <= cfg_data[END_W-1:0];
          CFG_HEADER_BYTES: header_r     <= cfg_data[HDR_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    func_r     <= func_nxt;
    tgt_r      <= tgt_nxt;
    isize_r    <= isize_nxt;
    iver_r     <= iver_nxt;
    cur_r      <= cur_nxt;
    req_r      <= req_nxt;
    creq_r     <= creq_nxt;
    used_r     <= used_nxt;
    res_ok_r   <= res_ok_nxt;
    res_err_r  <= res_err_nxt;
    res_addr_r <= res_addr_nxt;
    res_size_r <= res_size_nxt;
    res_ver_r  <= res_ver_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_addr_r[wr_idx] <= wr_addr;
      slot_size_r[wr_idx] <= wr_size;
      slot_ver_r[wr_idx]  <= wr_ver;
      slot_act_r[wr_idx]  <= wr_act;
    end else if (act_en) begin
      slot_act_r[idx_r[IDX_W-1:0]] <= act_val;
    end
  end

  // The table never holds more entries than it has rows.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");

  // A waiting result blocks new items.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready) else $error("input ready with result pending");

  // Compaction only runs on a non-empty table.
  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (count_r != '0)) else $error("shift on empty table");

  // An accepted item always starts work.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE)) else $error("item accepted but idle");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for image_slot_table_first_fit_unit.
// Depends on istff_pkg and the unit's RTL. A directed table runs first, then random items,
// under several area and header settings. Results are checked against a built-in
// table predictor, or against the expected values given in a typed directed row.
`timescale 1ns / 1ps

module tb;
  import istff_pkg::*;

  // One result item, split into its fields.
  typedef struct packed {
    logic              ok;
    logic [2:0]        err;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [VER_W-1:0]  ver;
    logic [END_W-1:0]  free;
    logic [3:0]        total;
  } slot_result_t;

  // One directed row. Where typed is set, the expected result is given in the row.
  typedef struct {
    func_t             fn;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [VER_W-1:0]  ver;
    bit                typed;
    slot_result_t      want;
  } op_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [22:0]  cfg_data;

  image_slot_table_first_fit_unit i_dut (.*);

  // The predictor's own copy of the configuration and of the slot table.
  longint unsigned area_lo, area_hi, hdr_len;
  longint unsigned tbl_addr [MAX_ENTRIES];
  longint unsigned tbl_size [MAX_ENTRIES];
  longint unsigned tbl_ver  [MAX_ENTRIES];
  bit              tbl_mark [MAX_ENTRIES];
  int              tbl_used;

  slot_result_t    pending_results[$];
  int              mismatches;
  int              stall_cycles;
  bit              steady;        // set while neither side idles
  longint unsigned last_hole;     // most recent address that find-free handed out

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint unsigned sector_up(longint unsigned x);
    return ((x + SECTOR_BYTES - 1) / SECTOR_BYTES) * SECTOR_BYTES;
  endfunction

  // Applies one operation to the predicted table and returns the result it gives.
  function automatic slot_result_t table_op(func_t fn, longint unsigned a,
                                            longint unsigned sz, longint unsigned v);
    slot_result_t    r;
    int              i;
    int              hit;
    bit              clear;
    longint unsigned req, cand, span, room, used;
    r = '0;
    hit = -1;
    case (fn)
      FN_REGISTER: begin
        for (i = tbl_used - 1; i >= 0; i--) if (tbl_addr[i] == a) hit = i;
        if (hit < 0 && tbl_used >= MAX_ENTRIES) begin
          r.err = ERR_TABLE_FULL;
        end else begin
          if (hit < 0) begin
            hit = tbl_used;
            tbl_used++;
          end
          tbl_addr[hit] = a;
          tbl_size[hit] = sz;
          tbl_ver[hit]  = v;
          tbl_mark[hit] = 1'b0;
          r.ok = 1'b1;
          r.addr = ADDR_W'(a);
          r.size = SIZE_W'(sz);
          r.ver = VER_W'(v);
        end
      end
      FN_ACTIVATE: begin
        // Every entry is touched: matches get the mark, all others lose it.
        for (i = 0; i < tbl_used; i++) begin
          tbl_mark[i] = (tbl_addr[i] == a);
          if (tbl_mark[i] && !r.ok) begin
            r.ok = 1'b1;
            r.addr = ADDR_W'(tbl_addr[i]);
            r.size = SIZE_W'(tbl_size[i]);
            r.ver = VER_W'(tbl_ver[i]);
          end
        end
        if (!r.ok) r.err = ERR_NOT_FOUND;
      end
      FN_DELETE, FN_GET_ACTIVE, FN_FIND_VERSION: begin
        for (i = tbl_used - 1; i >= 0; i--) begin
          if ((fn == FN_DELETE && tbl_addr[i] == a) ||
              (fn == FN_GET_ACTIVE && tbl_mark[i]) ||
              (fn == FN_FIND_VERSION && tbl_ver[i] == v)) hit = i;
        end
        if (hit < 0) begin
          r.err = ERR_NOT_FOUND;
        end else begin
          r.ok = 1'b1;
          r.addr = ADDR_W'(tbl_addr[hit]);
          r.size = SIZE_W'(tbl_size[hit]);
          r.ver = VER_W'(tbl_ver[hit]);
          if (fn == FN_DELETE) begin
            for (i = hit; i + 1 < tbl_used; i++) begin
              tbl_addr[i] = tbl_addr[i+1];
              tbl_size[i] = tbl_size[i+1];
              tbl_ver[i]  = tbl_ver[i+1];
              tbl_mark[i] = tbl_mark[i+1];
            end
            tbl_used--;
          end
        end
      end
      FN_FIND_FREE: begin
        if (sz == 0) begin
          r.err = ERR_ZERO_SIZE;
        end else begin
          req = sz + hdr_len;
          cand = sector_up(area_lo);
          while (!r.ok && cand + req <= area_hi) begin
            clear = 1'b1;
            for (i = 0; i < tbl_used && clear; i++) begin
              span = sector_up(tbl_addr[i] + tbl_size[i] + hdr_len);
              if (!(cand + req <= tbl_addr[i] || cand >= span)) begin
                clear = 1'b0;
                cand = span;
              end
            end
            r.ok = clear;
          end
          if (r.ok) begin
            r.addr = ADDR_W'(cand);
            last_hole = cand;
          end else begin
            r.err = ERR_NO_SPACE;
          end
        end
      end
      FN_FREE_SPACE: r.ok = 1'b1;
      default: ;
    endcase
    room = (area_hi > area_lo) ? area_hi - area_lo : 0;
    used = 0;
    for (i = 0; i < tbl_used; i++) used += sector_up(tbl_size[i] + hdr_len);
    r.free = END_W'((used >= room) ? 0 : room - used);
    r.total = 4'(tbl_used);
    return r;
  endfunction

  // Offers one item until the unit takes it. The expectation is queued first,
  // since no result can come back before the item is accepted.
  task automatic send_op(func_t fn, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] sz,
                         logic [VER_W-1:0] v, bit typed, slot_result_t want);
    slot_result_t guess;
    guess = table_op(fn, a, sz, v);
    pending_results.push_back(typed ? want : guess);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {4'b0, v, sz, a};
    do @(posedge clk); while (!in_tready);
    if (!steady && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Writes one register; the caller drops the valid after its last write.
  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AREA_START:   area_lo = val[ADDR_W-1:0];
      CFG_AREA_END:     area_hi = val;
      CFG_HEADER_BYTES: hdr_len = val[HDR_W-1:0];
      default: ;
    endcase
  endtask

  // Reconfigures only once every result is back and the unit has had time to settle.
  task automatic set_area(logic [22:0] lo, logic [22:0] hi, logic [22:0] hdr);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    write_reg(CFG_AREA_START, lo);
    write_reg(CFG_AREA_END, hi);
    write_reg(CFG_HEADER_BYTES, hdr);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 34);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    slot_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok    = out_tdata[0];
      got.err   = out_tdata[3:1];
      got.addr  = out_tdata[25:4];
      got.size  = out_tdata[47:26];
      got.ver   = out_tdata[79:48];
      got.free  = out_tdata[102:80];
      got.total = out_tdata[106:103];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: ok %b/%b err %0d/%0d addr %h/%h size %h/%h",
                      " ver %h/%h free %h/%h total %0d/%0d (exp/got)"},
                     want.ok, got.ok, want.err, got.err, want.addr, got.addr,
                     want.size, got.size, want.ver, got.ver, want.free, got.free,
                     want.total, got.total);
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which no channel moves an item means a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("image_slot_table_first_fit_unit: mismatch");
      $finish;
    end
  end

  initial begin
    op_row_t         rows[$];
    slot_result_t    none;
    logic [22:0]     area_sets[5][3];
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] sz;
    logic [VER_W-1:0]  v;
    func_t           fn;
    int              pick, n, p, k;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    stall_cycles = 0;
    steady = 1'b0;
    last_hole = 0;
    none = '0;
    area_lo = 0;
    area_hi = AREA_END_RESET;
    hdr_len = HEADER_RESET;
    tbl_used = 0;
    for (k = 0; k < MAX_ENTRIES; k++) begin
      tbl_addr[k] = 0;
      tbl_size[k] = 0;
      tbl_ver[k] = 0;
      tbl_mark[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first rows run on an empty table with reset settings,
    // so their results can be written down directly.
    rows.push_back('{FN_FREE_SPACE, 0, 0, 0, 1,
                     '{1'b1, ERR_NONE, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_GET_ACTIVE, 0, 0, 0, 1,
                     '{1'b0, ERR_NOT_FOUND, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_FIND_FREE, 0, 0, 0, 1,
                     '{1'b0, ERR_ZERO_SIZE, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_FIND_FREE, 0, 22'h3FFFFF, 0, 1,
                     '{1'b0, ERR_NO_SPACE, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_DELETE, 22'h3FFFFF, 0, 0, 1,
                     '{1'b0, ERR_NOT_FOUND, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_FIND_VERSION, 0, 0, 32'hFFFFFFFF, 1,
                     '{1'b0, ERR_NOT_FOUND, 0, 0, 0, AREA_END_RESET, 0}});
    rows.push_back('{FN_UNDEFINED, 22'h3FFFFF, 22'h3FFFFF, 32'hFFFFFFFF, 1,
                     '{1'b0, ERR_NONE, 0, 0, 0, AREA_END_RESET, 0}});
    // From here on the predictor supplies the expectation.
    rows.push_back('{FN_REGISTER, 0, 100, 1, 0, none});
    rows.push_back('{FN_FIND_FREE, 0, 100, 0, 0, none});
    rows.push_back('{FN_REGISTER, 22'h3FFFFF, 22'h3FFFFF, 32'hFFFFFFFF, 0, none});
    rows.push_back('{FN_REGISTER, 0, 0, 2, 0, none});   // same address: update, zero size
    rows.push_back('{FN_ACTIVATE, 22'h3FFFFF, 0, 0, 0, none});
    rows.push_back('{FN_GET_ACTIVE, 0, 0, 0, 0, none});
    rows.push_back('{FN_ACTIVATE, 22'h123, 0, 0, 0, none});  // no match still clears marks
    rows.push_back('{FN_GET_ACTIVE, 0, 0, 0, 0, none});
    rows.push_back('{FN_FIND_VERSION, 0, 0, 32'hFFFFFFFF, 0, none});
    rows.push_back('{FN_FREE_SPACE, 0, 0, 0, 0, none});
    for (k = 1; k <= 6; k++)
      rows.push_back('{FN_REGISTER, ADDR_W'(k * 22'h8000), 5000, k, 0, none});
    rows.push_back('{FN_REGISTER, 22'h1000, 1, 9, 0, none});    // table full
    rows.push_back('{FN_FIND_FREE, 0, 3000, 0, 0, none});       // jumps past regions
    rows.push_back('{FN_DELETE, 22'h8000, 0, 0, 0, none});      // compaction
    foreach (rows[i]) send_op(rows[i].fn, rows[i].addr, rows[i].size, rows[i].ver,
                              rows[i].typed, rows[i].want);

    // Random part, one phase per setting of the area and header length.
    area_sets = '{'{23'd0, AREA_END_RESET, HEADER_RESET},
                  '{23'd0, 23'h400000, 23'hFFF},
                  '{23'h3FFFFF, 23'd0, 23'd0},
                  '{23'h1234, 23'h200000, 23'd64},
                  '{23'h20800, 23'h60000, 23'd500}};
    n = 0;
    for (p = 0; p < 5; p++) begin
      set_area(area_sets[p][0], area_sets[p][1], area_sets[p][2]);
      for (k = 0; k < 290; k++) begin
        steady = (n >= 600 && n < 800);
        n++;
        pick = $urandom_range(0, 99);
        if (pick < 30) fn = FN_REGISTER;
        else if (pick < 42) fn = FN_ACTIVATE;
        else if (pick < 57) fn = FN_DELETE;
        else if (pick < 72) fn = FN_FIND_FREE;
        else if (pick < 78) fn = FN_FREE_SPACE;
        else if (pick < 86) fn = FN_GET_ACTIVE;
        else if (pick < 95) fn = FN_FIND_VERSION;
        else fn = FN_UNDEFINED;
        // Addresses mostly come from a small pool or from the last free hole,
        // so that updates, activations and deletes keep finding their entry.
        pick = $urandom_range(0, 99);
        if (pick < 70)
          a = ADDR_W'($urandom_range(0, 11) * 22'h10000 + area_sets[p][0][21:0]);
        else if (pick < 85) a = last_hole[ADDR_W-1:0];
        else a = ADDR_W'($urandom_range(0, 22'h3FFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 5) sz = 0;
        else if (pick < 80) sz = SIZE_W'($urandom_range(1, 20000));
        else sz = SIZE_W'($urandom_range(0, 22'h3FFFFF));
        v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom;
        send_op(fn, a, sz, v, 1'b0, none);
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("image_slot_table_first_fit_unit: match");
    end else begin
      $display("image_slot_table_first_fit_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/istff_pkg.sv
sv/image_slot_table_first_fit_unit.sv
dv/tb.sv
